// File: hw/rtl/orov_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the oriented rectangle overlap test
// no dependencies
package orov_pkg;

    // default depth of the sine table, entries per full turn
    localparam int SINE_DEPTH_DEFAULT = 1024;
    // depth of the queue between the front and the back part
    localparam int QUEUE_DEPTH = 2;
    // scale register value after reset, 1.0 in Q8.8
    localparam logic [15:0] SCALE_RESET = 16'd256;

    // corner coordinate, difference and cross product widths
    localparam int CW = 28;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NSIDE = 48;

    // sine generation constants: pi/2 in Q30, one in Q1.14, taylor divisors
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] TRIG_ONE = 64'd16384;
    localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};

    // verdict codes
    localparam logic [2:0] VERDICT_LAYER  = 3'd0;
    localparam logic [2:0] VERDICT_QUICK  = 3'd1;
    localparam logic [2:0] VERDICT_EXTENT = 3'd2;
    localparam logic [2:0] VERDICT_EDGE   = 3'd3;
    localparam logic [2:0] VERDICT_DIAG   = 3'd4;
    localparam logic [2:0] VERDICT_NONE   = 3'd5;

    typedef struct packed {
        logic signed [23:0] first_x;
        logic signed [23:0] first_y;
        logic [15:0]        first_heading;
        logic [15:0]        first_half_width;
        logic [15:0]        first_half_length;
        logic signed [23:0] second_x;
        logic signed [23:0] second_y;
        logic [15:0]        second_heading;
        logic [15:0]        second_half_width;
        logic [15:0]        second_half_length;
        logic               layer_ok;
        logic               use_quick_accept;
    } t_in_item;

    typedef struct packed {
        logic       overlap;
        logic [2:0] verdict;
    } t_out_item;

    // classified item as held in the queue
    typedef struct packed {
        t_in_item    item;
        logic        quick_en;
        logic [16:0] min_sum;
    } t_job;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

endpackage

// File: hw/rtl/orov_sine_rom.sv
`timescale 1ns / 1ps
// sine table in Q1.14, one registered read port
// depends on orov_pkg
module orov_sine_rom import orov_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IDX_W-1:0]    i_idx,
    output logic signed [15:0]  o_val
);

    typedef logic signed [15:0] t_sin_tab [SINE_TABLE_DEPTH];

    // quarter-wave fold and taylor series, evaluated at elaboration
    function automatic t_sin_tab build_tab();
        t_sin_tab    tab;
        logic [63:0] t, quad, r, x, x2, term, pos, neg, s, q;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t    = (64'(i) << 32) / SINE_TABLE_DEPTH;
            quad = (t >> 30) & 64'd3;
            r    = t & 64'h3FFF_FFFF;
            if (quad[0]) begin
                r = 64'h4000_0000 - r;
            end
            x    = (r * PI_HALF_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k[0]) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            q = (s + 64'd32768) >> 16;
            if (q > TRIG_ONE) begin
                q = TRIG_ONE;
            end
            tab[i] = quad[1] ? -$signed(16'(q)) : $signed(16'(q));
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_tab();

    logic signed [15:0] r_val;

    // registered lookup
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= SIN_TAB[i_idx];
        end
    end

    assign o_val = r_val;

endmodule

// File: hw/rtl/orov_fifo.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back
// depends on orov_pkg
module orov_fifo import orov_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'((32'(r_wr_ptr) + 1) % QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'((32'(r_rd_ptr) + 1) % QUEUE_DEPTH);
            end
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// File: hw/rtl/orov_front.sv
`timescale 1ns / 1ps
// front part: takes input beats and classifies them for the back part
// depends on orov_pkg
module orov_front import orov_pkg::*; (
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    logic [15:0] w_min1, w_min2;

    // smaller half extent of each rectangle for the quick accept
    always_comb begin
        w_min1 = (i_in_item.first_half_width < i_in_item.first_half_length) ?
                 i_in_item.first_half_width : i_in_item.first_half_length;
        w_min2 = (i_in_item.second_half_width < i_in_item.second_half_length) ?
                 i_in_item.second_half_width : i_in_item.second_half_length;
    end

    // classify: layer gate and quick accept enable
    always_comb begin
        o_job.item     = i_in_item;
        o_job.quick_en = i_in_item.layer_ok & i_in_item.use_quick_accept;
        o_job.min_sum  = 17'(w_min1) + 17'(w_min2);
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid & ~i_full;

endmodule

// File: hw/rtl/orov_back.sv
`timescale 1ns / 1ps
// back part: corner generation, extent reject and crossing tests, six stages
// depends on orov_pkg and orov_sine_rom
module orov_back import orov_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_scale,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_pop,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    logic w_en;
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic r_out_valid;
    t_out_item r_out_item;

    assign w_en      = ~r_out_valid | ~i_out_stall;
    assign o_job_pop = w_en & i_job_valid;

    // ---------------- stage 1: table reads, scaled extents, centre deltas
    logic [IDX_W-1:0]   w_idx [4];
    logic signed [15:0] w_trig [4];
    logic [15:0]        w_head [4];

    always_comb begin
        w_head[0] = i_job.item.first_heading;
        w_head[1] = i_job.item.first_heading + 16'h4000;
        w_head[2] = i_job.item.second_heading;
        w_head[3] = i_job.item.second_heading + 16'h4000;
        for (int k = 0; k < 4; k++) begin
            w_idx[k] = IDX_W'((32'(w_head[k]) * 32'(SINE_TABLE_DEPTH)) >> 16);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_rom
        orov_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_idx (w_idx[g]),
            .o_val (w_trig[g])
        );
    end

    logic [31:0]        r1_w [2];
    logic [31:0]        r1_l [2];
    logic signed [23:0] r1_cx [2];
    logic signed [23:0] r1_cy [2];
    logic signed [24:0] r1_dx, r1_dy;
    logic [24:0]        r1_thr;
    logic               r1_layer, r1_quick_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_w[0]     <= 32'(i_job.item.first_half_width) * 32'(i_scale);
            r1_l[0]     <= 32'(i_job.item.first_half_length) * 32'(i_scale);
            r1_w[1]     <= 32'(i_job.item.second_half_width) * 32'(i_scale);
            r1_l[1]     <= 32'(i_job.item.second_half_length) * 32'(i_scale);
            r1_cx[0]    <= i_job.item.first_x;
            r1_cy[0]    <= i_job.item.first_y;
            r1_cx[1]    <= i_job.item.second_x;
            r1_cy[1]    <= i_job.item.second_y;
            r1_dx       <= 25'(i_job.item.second_x) - 25'(i_job.item.first_x);
            r1_dy       <= 25'(i_job.item.second_y) - 25'(i_job.item.first_y);
            r1_thr      <= 25'((33'(i_scale) * 33'(i_job.min_sum)) >> 8);
            r1_layer    <= i_job.item.layer_ok;
            r1_quick_en <= i_job.quick_en;
        end
    end

    // ---------------- stage 2: rotation products and squared distances
    logic signed [47:0] r2_sl [2], r2_cw [2], r2_cl [2], r2_sw [2];
    logic [49:0]        r2_d2, r2_thr2;
    logic signed [23:0] r2_cx [2], r2_cy [2];
    logic               r2_layer, r2_quick_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 2; r++) begin
                r2_sl[r] <= 48'(w_trig[2*r])   * $signed({16'b0, r1_l[r]});
                r2_cw[r] <= 48'(w_trig[2*r+1]) * $signed({16'b0, r1_w[r]});
                r2_cl[r] <= 48'(w_trig[2*r+1]) * $signed({16'b0, r1_l[r]});
                r2_sw[r] <= 48'(w_trig[2*r])   * $signed({16'b0, r1_w[r]});
                r2_cx[r] <= r1_cx[r];
                r2_cy[r] <= r1_cy[r];
            end
            r2_d2       <= 50'(50'(r1_dx) * 50'(r1_dx)) + 50'(50'(r1_dy) * 50'(r1_dy));
            r2_thr2     <= 50'(r1_thr) * 50'(r1_thr);
            r2_layer    <= r1_layer;
            r2_quick_en <= r1_quick_en;
        end
    end

    // ---------------- stage 3: corners rounded to Q.8, quick accept
    function automatic logic signed [CW-1:0] to_q8(input logic signed [48:0] v);
        logic signed [48:0] w;
        w = v + 49'sd2097152;
        return CW'(w >>> 22);
    endfunction

    t_pt  r3_p [2][4];
    logic r3_layer, r3_quick;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 2; r++) begin
                r3_p[r][0].x <= CW'(r2_cx[r]) + to_q8(49'(r2_sl[r]) - 49'(r2_cw[r]));
                r3_p[r][0].y <= CW'(r2_cy[r]) + to_q8(49'(r2_cl[r]) + 49'(r2_sw[r]));
                r3_p[r][1].x <= CW'(r2_cx[r]) + to_q8(49'(r2_sl[r]) + 49'(r2_cw[r]));
                r3_p[r][1].y <= CW'(r2_cy[r]) + to_q8(49'(r2_cl[r]) - 49'(r2_sw[r]));
                r3_p[r][2].x <= CW'(r2_cx[r]) + to_q8(-49'(r2_sl[r]) + 49'(r2_cw[r]));
                r3_p[r][2].y <= CW'(r2_cy[r]) + to_q8(-49'(r2_cl[r]) - 49'(r2_sw[r]));
                r3_p[r][3].x <= CW'(r2_cx[r]) + to_q8(-49'(r2_sl[r]) - 49'(r2_cw[r]));
                r3_p[r][3].y <= CW'(r2_cy[r]) + to_q8(-49'(r2_cl[r]) + 49'(r2_sw[r]));
            end
            r3_layer <= r2_layer;
            r3_quick <= r2_quick_en & (r2_d2 < r2_thr2);
        end
    end

    // ---------------- stage 4: extent reject and side vectors
    logic [1:0] w_top [2];
    logic       w_rej;
    t_pt        w_so [NSIDE], w_sp [NSIDE], w_sq [NSIDE];

    always_comb begin
        // top corner, ties keep the lower index
        for (int r = 0; r < 2; r++) begin
            w_top[r] = 2'd0;
            for (int i = 1; i < 4; i++) begin
                if (r3_p[r][i].y > r3_p[r][w_top[r]].y) begin
                    w_top[r] = 2'(i);
                end
            end
        end
        w_rej = (r3_p[0][w_top[0]].y < r3_p[1][2'(w_top[1] + 2'd2)].y) ||
                (r3_p[1][w_top[1]].y < r3_p[0][2'(w_top[0] + 2'd2)].y) ||
                (r3_p[0][2'(w_top[0] + 2'd1)].x < r3_p[1][2'(w_top[1] + 2'd3)].x) ||
                (r3_p[1][2'(w_top[1] + 2'd1)].x < r3_p[0][2'(w_top[0] + 2'd3)].x);
        // edge sides of both rectangles, then the two diagonals of each
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_so[i*4+j]    = r3_p[0][i];
                w_sp[i*4+j]    = r3_p[0][2'(i+1)];
                w_sq[i*4+j]    = r3_p[1][j];
                w_so[16+j*4+i] = r3_p[1][j];
                w_sp[16+j*4+i] = r3_p[1][2'(j+1)];
                w_sq[16+j*4+i] = r3_p[0][i];
            end
        end
        for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < 4; j++) begin
                w_so[32+a*4+j] = r3_p[0][a];
                w_sp[32+a*4+j] = r3_p[0][a+2];
                w_sq[32+a*4+j] = r3_p[1][j];
                w_so[40+a*4+j] = r3_p[1][a];
                w_sp[40+a*4+j] = r3_p[1][a+2];
                w_sq[40+a*4+j] = r3_p[0][j];
            end
        end
    end

    logic signed [DW-1:0] r4_ax [NSIDE], r4_ay [NSIDE], r4_bx [NSIDE], r4_by [NSIDE];
    logic                 r4_layer, r4_quick, r4_rej;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NSIDE; k++) begin
                r4_ax[k] <= DW'(w_sp[k].x) - DW'(w_so[k].x);
                r4_ay[k] <= DW'(w_sp[k].y) - DW'(w_so[k].y);
                r4_bx[k] <= DW'(w_sq[k].x) - DW'(w_so[k].x);
                r4_by[k] <= DW'(w_sq[k].y) - DW'(w_so[k].y);
            end
            r4_layer <= r3_layer;
            r4_quick <= r3_quick;
            r4_rej   <= w_rej;
        end
    end

    // ---------------- stage 5: cross product halves
    logic signed [PW-1:0] r5_m1 [NSIDE], r5_m2 [NSIDE];
    logic                 r5_layer, r5_quick, r5_rej;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NSIDE; k++) begin
                r5_m1[k] <= PW'(r4_ax[k]) * PW'(r4_by[k]);
                r5_m2[k] <= PW'(r4_ay[k]) * PW'(r4_bx[k]);
            end
            r5_layer <= r4_layer;
            r5_quick <= r4_quick;
            r5_rej   <= r4_rej;
        end
    end

    // ---------------- stage 6: side signs
    logic signed [PW:0] w_side [NSIDE];
    logic [NSIDE-1:0]   r6_pos, r6_neg;
    logic               r6_layer, r6_quick, r6_rej;

    always_comb begin
        for (int k = 0; k < NSIDE; k++) begin
            w_side[k] = (PW+1)'(r5_m1[k]) - (PW+1)'(r5_m2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NSIDE; k++) begin
                r6_pos[k] <= (w_side[k] > 0);
                r6_neg[k] <= w_side[k][PW];
            end
            r6_layer <= r5_layer;
            r6_quick <= r5_quick;
            r6_rej   <= r5_rej;
        end
    end

    // ---------------- crossing decision and result
    // c, d not strictly on one side of ab; a, b strictly on opposite sides of cd
    function automatic logic crosses(input logic p1, n1, p2, n2, p3, n3, p4, n4);
        return ~((p1 & p2) | (n1 & n2)) & ((p3 & n4) | (n3 & p4));
    endfunction

    logic      w_edge, w_diag;
    t_out_item w_res;

    always_comb begin
        w_edge = 1'b0;
        w_diag = 1'b0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_edge = w_edge | crosses(
                    r6_pos[i*4+j],           r6_neg[i*4+j],
                    r6_pos[i*4+((j+1)%4)],   r6_neg[i*4+((j+1)%4)],
                    r6_pos[16+j*4+i],        r6_neg[16+j*4+i],
                    r6_pos[16+j*4+((i+1)%4)], r6_neg[16+j*4+((i+1)%4)]);
            end
        end
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                w_diag = w_diag | crosses(
                    r6_pos[32+a*4+b],   r6_neg[32+a*4+b],
                    r6_pos[32+a*4+b+2], r6_neg[32+a*4+b+2],
                    r6_pos[40+b*4+a],   r6_neg[40+b*4+a],
                    r6_pos[40+b*4+a+2], r6_neg[40+b*4+a+2]);
            end
        end
        // fixed priority of the tests
        if (!r6_layer) begin
            w_res = '{overlap: 1'b0, verdict: VERDICT_LAYER};
        end else if (r6_quick) begin
            w_res = '{overlap: 1'b1, verdict: VERDICT_QUICK};
        end else if (r6_rej) begin
            w_res = '{overlap: 1'b0, verdict: VERDICT_EXTENT};
        end else if (w_edge) begin
            w_res = '{overlap: 1'b1, verdict: VERDICT_EDGE};
        end else if (w_diag) begin
            w_res = '{overlap: 1'b1, verdict: VERDICT_DIAG};
        end else begin
            w_res = '{overlap: 1'b0, verdict: VERDICT_NONE};
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_v        <= i_job_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r6_v        <= r5_v;
            r_out_valid <= r6_v;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hw/rtl/oriented_rectangle_overlap_test.sv
`timescale 1ns / 1ps
// top level of the oriented rectangle overlap test
// depends on orov_pkg, orov_front, orov_fifo, orov_back
//
//  channel | direction | handshake                | beat
//  in      | input     | i_in_valid / o_in_stall  | t_in_item, two rectangles
//  out     | output    | o_out_valid / i_out_stall| t_out_item, overlap and verdict
//  cfg     | input     | i_cfg_we                 | i_cfg_data, size scale Q8.8
//
// one pair per cycle sustained while the output is not stalled; a beat passes
// the queue and six back stages (table read, rotation multiply,
// corner rounding, extent and side vectors, cross products, signs), the last
// of which feeds the output register.
// reset is synchronous, clears all valid flags and sets the scale to 1.0.
// an output stall freezes the back pipeline; the two-entry queue then fills
// and raises o_in_stall.
module oriented_rectangle_overlap_test import orov_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_scale;
    logic        w_full, w_push, w_pop, w_job_valid;
    t_job        w_job_in, w_job_out;

    // size scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    orov_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    orov_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_data  (w_job_out)
    );

    orov_back #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (r_scale),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // verdict code stays within the defined set
    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.verdict <= VERDICT_NONE))
        else $error("verdict code out of range");

    // overlap agrees with the deciding test
    a_overlap_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.overlap ==
            ((o_out_item.verdict == VERDICT_QUICK) ||
             (o_out_item.verdict == VERDICT_EDGE) ||
             (o_out_item.verdict == VERDICT_DIAG))))
        else $error("overlap does not match verdict");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present after reset");

    // queue only pops when it holds a beat
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_job_valid)
        else $error("queue popped while empty");

endmodule
